FILE: hw/rtl/hsvr_pkg.sv
// ----------------------------------------------------------------------------
// hsvr_pkg
// Shared constants, codes and helper functions of the HSV ramp palette block.
// ----------------------------------------------------------------------------
package hsvr_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int RAMP_STEPS = 255;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int HUE_W      = FRAC_BITS;
	localparam int UNIT_W     = FRAC_BITS + 1;
	localparam int STEP_W     = 8;
	localparam int CHAN_W     = 8;

	// The ramp numerator is biased by RAMP_STEPS * ONE so that it is never negative.
	localparam int NUM_W      = 25;
	localparam int RAMP_OFS   = RAMP_STEPS * ONE;

	// Reciprocal of the step count; the estimate is low by at most one.
	localparam int DIV_SHIFT  = 25;
	localparam int QUO_W      = 18;
	localparam logic [QUO_W-1:0] RECIP = QUO_W'((2 ** DIV_SHIFT) / RAMP_STEPS);

	localparam int APB_AW     = 5;

	typedef enum logic [2:0] {
		REG_START_HUE = 3'd0,
		REG_START_SAT = 3'd1,
		REG_START_BRI = 3'd2,
		REG_END_HUE   = 3'd3,
		REG_END_SAT   = 3'd4,
		REG_END_BRI   = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} hue_sector_t;

	function automatic logic [UNIT_W-1:0] clamp_unit(input logic [UNIT_W-1:0] val);
		logic [UNIT_W-1:0] res;
		if (val > UNIT_W'(ONE)) begin
			res = UNIT_W'(ONE);
		end else begin
			res = val;
		end
		return res;
	endfunction

	// Biased numerator k * (end - start) + RAMP_STEPS * ONE.
	function automatic logic [NUM_W-1:0] ramp_num(
		input logic [STEP_W-1:0] k,
		input logic [UNIT_W-1:0] a,
		input logic [UNIT_W-1:0] z
	);
		logic signed [UNIT_W:0]  diff;
		logic signed [26:0]      num;
		diff = $signed({1'b0, z}) - $signed({1'b0, a});
		num  = $signed({1'b0, k}) * diff + $signed(27'(RAMP_OFS));
		return num[NUM_W-1:0];
	endfunction

	function automatic logic [UNIT_W-1:0] sat_clamp(input logic signed [UNIT_W+1:0] val);
		logic [UNIT_W-1:0] res;
		if (val < 0) begin
			res = '0;
		end else if (val > $signed((UNIT_W+2)'(ONE))) begin
			res = UNIT_W'(ONE);
		end else begin
			res = val[UNIT_W-1:0];
		end
		return res;
	endfunction

endpackage

FILE: hw/rtl/hsv_ramp_to_rgb.sv
// ----------------------------------------------------------------------------
// hsv_ramp_to_rgb
// Palette ramp generator: interpolates hue, saturation and brightness between
// two configured end points and converts the result to 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the slave stream carries a ramp step index; each transfer
// on the master stream carries one RGB palette entry, in the same order.
// The six end-point registers are written through the APB port; the user must
// write them only while the stream is idle, which the block itself does not enforce. Reads return the stored values.
// The datapath is six register stages deep: ramp numerators, reciprocal-multiply
// division, quotient correction, sector split, factor products and channel
// products. One step can be accepted in every cycle unless a receiver stall has
// backed up to the input stage. Each stage holds its own valid bit, so when the
// receiver stalls, the held result stays in the output register while empty
// stages upstream keep filling; nothing is lost or repeated.
// Reset clears all valid bits and returns the registers to a full-saturation,
// full-brightness ramp at hue zero.
// ----------------------------------------------------------------------------
module hsv_ramp_to_rgb (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hsvr_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,

	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] step_index

	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata    // [7:0] red_out, [15:8] green_out,
	                                                // [23:16] blue_out
);
	import hsvr_pkg::*;

	logic [HUE_W-1:0]  start_hue_q, end_hue_q;
	logic [UNIT_W-1:0] start_sat_q, start_bri_q, end_sat_q, end_bri_q;
	logic [UNIT_W-1:0] s0c, s1c, b0c, b1c;
	logic              cfg_wr;
	cfg_reg_t          cfg_sel;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	logic [NUM_W-1:0]  xh_s1, xs_s1, xb_s1;
	logic [NUM_W-1:0]  xh_s2, xs_s2, xb_s2;
	logic [QUO_W-1:0]  qh_s2, qs_s2, qb_s2;
	logic [HUE_W-1:0]  hue_s3;
	logic [UNIT_W-1:0] sat_s3, bri_s3;
	logic [2:0]        sector_s4;
	logic [HUE_W-1:0]  frac_s4;
	logic [UNIT_W-1:0] sat_s4;
	logic [23:0]       bri255_s4;
	logic [CHAN_W-1:0] val_s4;
	logic [2:0]        sector_s5;
	logic [23:0]       bri255_s5;
	logic [CHAN_W-1:0] val_s5;
	logic [UNIT_W-1:0] fp_s5, fq_s5, ft_s5;
	logic [CHAN_W-1:0] red_s6, green_s6, blue_s6;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_sel = cfg_reg_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hue_q <= '0;
			start_sat_q <= UNIT_W'(ONE);
			start_bri_q <= UNIT_W'(ONE);
			end_hue_q   <= '0;
			end_sat_q   <= UNIT_W'(ONE);
			end_bri_q   <= UNIT_W'(ONE);
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_START_HUE: start_hue_q <= pwdata[HUE_W-1:0];
				REG_START_SAT: start_sat_q <= pwdata[UNIT_W-1:0];
				REG_START_BRI: start_bri_q <= pwdata[UNIT_W-1:0];
				REG_END_HUE:   end_hue_q   <= pwdata[HUE_W-1:0];
				REG_END_SAT:   end_sat_q   <= pwdata[UNIT_W-1:0];
				REG_END_BRI:   end_bri_q   <= pwdata[UNIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_START_HUE: prdata = {16'b0, start_hue_q};
			REG_START_SAT: prdata = {15'b0, start_sat_q};
			REG_START_BRI: prdata = {15'b0, start_bri_q};
			REG_END_HUE:   prdata = {16'b0, end_hue_q};
			REG_END_SAT:   prdata = {15'b0, end_sat_q};
			REG_END_BRI:   prdata = {15'b0, end_bri_q};
			default:       prdata = '0;
		endcase
	end

	assign s0c = clamp_unit(start_sat_q);
	assign s1c = clamp_unit(end_sat_q);
	assign b0c = clamp_unit(start_bri_q);
	assign b1c = clamp_unit(end_bri_q);

	assign adv6     = !vld_s6 || m_tready;
	assign adv5     = !vld_s5 || adv6;
	assign adv4     = !vld_s4 || adv5;
	assign adv3     = !vld_s3 || adv4;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= s_tvalid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: biased ramp numerators.
	always_ff @(posedge clk) begin
		if (adv1) begin
			xh_s1 <= ramp_num(s_tdata, {1'b0, start_hue_q}, {1'b0, end_hue_q});
			xs_s1 <= ramp_num(s_tdata, s0c, s1c);
			xb_s1 <= ramp_num(s_tdata, b0c, b1c);
		end
	end

	// Stage 2: quotient estimates by reciprocal multiplication.
	logic [NUM_W+QUO_W-1:0] ph, ps, pb;
	assign ph = xh_s1 * RECIP;
	assign ps = xs_s1 * RECIP;
	assign pb = xb_s1 * RECIP;

	always_ff @(posedge clk) begin
		if (adv2) begin
			xh_s2 <= xh_s1;
			xs_s2 <= xs_s1;
			xb_s2 <= xb_s1;
			qh_s2 <= ph[DIV_SHIFT +: QUO_W];
			qs_s2 <= ps[DIV_SHIFT +: QUO_W];
			qb_s2 <= pb[DIV_SHIFT +: QUO_W];
		end
	end

	// Stage 3: quotient correction and interpolated HSB values.
	function automatic logic [QUO_W-1:0] quo_fix(
		input logic [NUM_W-1:0] x,
		input logic [QUO_W-1:0] qe
	);
		logic [NUM_W:0] q255;
		logic [NUM_W:0] rem;
		q255 = {qe, 8'b0} - {8'b0, qe};
		rem  = {1'b0, x} - q255;
		return qe + QUO_W'(rem >= (NUM_W+1)'(RAMP_STEPS));
	endfunction

	logic [QUO_W-1:0]        qh, qs, qb;
	logic signed [UNIT_W+1:0] sum_s, sum_b;
	assign qh    = quo_fix(xh_s2, qh_s2);
	assign qs    = quo_fix(xs_s2, qs_s2);
	assign qb    = quo_fix(xb_s2, qb_s2);
	assign sum_s = $signed({2'b0, s0c}) + $signed({1'b0, qs}) - $signed((UNIT_W+2)'(ONE));
	assign sum_b = $signed({2'b0, b0c}) + $signed({1'b0, qb}) - $signed((UNIT_W+2)'(ONE));

	always_ff @(posedge clk) begin
		if (adv3) begin
			hue_s3 <= start_hue_q + qh[HUE_W-1:0];
			sat_s3 <= sat_clamp(sum_s);
			bri_s3 <= sat_clamp(sum_b);
		end
	end

	// Stage 4: hue sector and fraction, scaled brightness.
	logic [HUE_W+2:0] hue6;
	logic [23:0]      bri255;
	assign hue6   = {hue_s3, 2'b0} + {1'b0, hue_s3, 1'b0};
	assign bri255 = {bri_s3[15:0], 8'b0} - {7'b0, bri_s3};

	always_ff @(posedge clk) begin
		if (adv4) begin
			sector_s4 <= hue6[HUE_W +: 3];
			frac_s4   <= hue6[HUE_W-1:0];
			sat_s4    <= sat_s3;
			bri255_s4 <= (bri_s3[UNIT_W-1]) ? 24'(255 * ONE) : bri255;
			val_s4    <= (bri_s3[UNIT_W-1]) ? CHAN_W'(255) : bri255[23:16];
		end
	end

	// Stage 5: the p, q and t factors.
	logic [UNIT_W-1:0]  inv_frac;
	logic [2*UNIT_W-1:0] sfq, sft;
	assign inv_frac = UNIT_W'(ONE) - {1'b0, frac_s4};
	assign sfq      = sat_s4 * {1'b0, frac_s4};
	assign sft      = sat_s4 * inv_frac;

	always_ff @(posedge clk) begin
		if (adv5) begin
			sector_s5 <= sector_s4;
			bri255_s5 <= bri255_s4;
			val_s5    <= val_s4;
			fp_s5     <= UNIT_W'(ONE) - sat_s4;
			fq_s5     <= UNIT_W'(ONE) - sfq[FRAC_BITS +: UNIT_W];
			ft_s5     <= UNIT_W'(ONE) - sft[FRAC_BITS +: UNIT_W];
		end
	end

	// Stage 6: channel products and sector selection.
	logic [40:0]       mp, mq, mt;
	logic [CHAN_W-1:0] cp, cq, ct;
	logic [CHAN_W-1:0] red_d, green_d, blue_d;
	assign mp = bri255_s5 * fp_s5;
	assign mq = bri255_s5 * fq_s5;
	assign mt = bri255_s5 * ft_s5;
	assign cp = mp[2*FRAC_BITS +: CHAN_W];
	assign cq = mq[2*FRAC_BITS +: CHAN_W];
	assign ct = mt[2*FRAC_BITS +: CHAN_W];

	always_comb begin
		unique case (hue_sector_t'(sector_s5))
			SEC_RED_YEL: begin red_d = val_s5; green_d = ct;     blue_d = cp;     end
			SEC_YEL_GRN: begin red_d = cq;     green_d = val_s5; blue_d = cp;     end
			SEC_GRN_CYN: begin red_d = cp;     green_d = val_s5; blue_d = ct;     end
			SEC_CYN_BLU: begin red_d = cp;     green_d = cq;     blue_d = val_s5; end
			SEC_BLU_MAG: begin red_d = ct;     green_d = cp;     blue_d = val_s5; end
			default:     begin red_d = val_s5; green_d = cp;     blue_d = cq;     end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			red_s6   <= red_d;
			green_s6 <= green_d;
			blue_s6  <= blue_d;
		end
	end

	assign m_tvalid = vld_s6;
	assign m_tdata  = {blue_s6, green_s6, red_s6};

endmodule
